// ===== rtl/core/lel_pkg.sv =====
// ----------------------------------------------------------------------------
// lel_pkg
// Shared constants, codes and types of the lifecycle event log.
// ----------------------------------------------------------------------------
package lel_pkg;

    localparam int EVENT_DEPTH = 16;
    localparam int MAX_RESULTS = 16;
    localparam int BYTE_SHIFT  = 3;
    localparam int KIND_W      = 3;
    localparam int CAP_W       = 16;
    localparam int LEASE_W     = 16;
    localparam int IDX_W       = $clog2(EVENT_DEPTH);
    localparam int CNT_W       = $clog2(EVENT_DEPTH + 1);
    localparam int LEFT_W      = $clog2(MAX_RESULTS + 1);
    localparam int CAPN_W      = CAP_W - BYTE_SHIFT;

    localparam logic [LEASE_W-1:0] LEASE_MAX = {LEASE_W{1'b1}};

    typedef enum logic [KIND_W-1:0] {
        K_START,
        K_STOP,
        K_LEASE_OPEN,
        K_LEASE_CLOSE,
        K_BEGIN_DELETE,
        K_READ
    } t_kind;

    typedef enum logic [1:0] {
        LOG_CREATED,
        LOG_STARTED,
        LOG_STOPPED,
        LOG_DELETED
    } t_event;

    typedef struct packed {
        logic   push;
        t_event code;
        logic   pop;
        logic   rd_en;
    } t_ring_cmd;

endpackage

// ===== rtl/core/lel_ifs.sv =====
// ----------------------------------------------------------------------------
// lel_ifs
// Command and result channels of the lifecycle event log.
// ----------------------------------------------------------------------------
interface lel_cmd_if import lel_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] kind;
    logic [CAP_W-1:0]  read_capacity;

    modport source (output valid, kind, read_capacity, input ready);
    modport sink   (input valid, kind, read_capacity, output ready);
endinterface

interface lel_res_if ();
    logic       valid;
    logic       ready;
    logic       accepted;
    logic       close_delete;
    logic       is_stopped;
    logic       is_deleting;
    logic       events_pending;
    logic       event_valid;
    logic [1:0] event_code;
    logic       last;

    modport source (output valid, accepted, close_delete, is_stopped, is_deleting,
                    events_pending, event_valid, event_code, last, input ready);
    modport sink   (input valid, accepted, close_delete, is_stopped, is_deleting,
                    events_pending, event_valid, event_code, last, output ready);
endinterface

// ===== rtl/core/lifecycle_event_log.sv =====
// ----------------------------------------------------------------------------
// lifecycle_event_log
// Lifecycle controller with an overwrite-oldest event ring.
//
//   port     dir   beat
//   i_cmd    in    one command: kind, read_capacity
//   o_res    out   one result: status flags, optional drained event, last
//
// a command yields one beat, but a read that drains n events yields n beats:
// each event is a ring memory read (registered) followed by an emit into
// the result register
// the ring needs no clearing pass; its two initial entries come up at reset
// a stalled result holds the block: the next command waits for the slot
// ----------------------------------------------------------------------------
module lifecycle_event_log import lel_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    lel_cmd_if.sink   i_cmd,
    lel_res_if.source o_res
);

    t_ring_cmd        w_ring_cmd;
    logic [CNT_W-1:0] w_fill;
    t_event           w_rd_code;

    lel_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (i_cmd),
        .o_res      (o_res),
        .o_ring_cmd (w_ring_cmd),
        .i_fill     (w_fill),
        .i_rd_code  (w_rd_code)
    );

    lel_ring u_ring (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (w_ring_cmd),
        .o_fill    (w_fill),
        .o_rd_code (w_rd_code)
    );

endmodule

// ===== rtl/core/lel_ring.sv =====
// ----------------------------------------------------------------------------
// lel_ring
// Event ring memory with head and fill tracking; a full ring drops its oldest.
// ----------------------------------------------------------------------------
module lel_ring import lel_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_ring_cmd        i_cmd,
    output logic [CNT_W-1:0] o_fill,
    output t_event           o_rd_code
);

    t_event                 mem [EVENT_DEPTH];
    logic [EVENT_DEPTH-1:0] r_written;
    logic [IDX_W-1:0]       r_head;
    logic [CNT_W-1:0]       r_fill;
    t_event                 r_rd_data;
    logic                   r_rd_written;
    logic [IDX_W-1:0]       r_rd_idx;

    logic [IDX_W:0]   w_sum;
    logic [IDX_W-1:0] w_slot;
    logic [IDX_W-1:0] w_head_inc;
    logic             w_full;

    assign w_sum      = {1'b0, r_head} + (IDX_W+1)'(r_fill);
    assign w_slot     = (w_sum >= (IDX_W+1)'(EVENT_DEPTH))
                        ? IDX_W'(w_sum - (IDX_W+1)'(EVENT_DEPTH)) : w_sum[IDX_W-1:0];
    assign w_head_inc = (r_head == IDX_W'(EVENT_DEPTH - 1)) ? '0 : r_head + 1'b1;
    assign w_full     = (r_fill == CNT_W'(EVENT_DEPTH));

    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            mem[w_slot] <= i_cmd.code;
        end
        if (i_cmd.rd_en) begin
            r_rd_data    <= mem[r_head];
            r_rd_written <= r_written[r_head];
            r_rd_idx     <= r_head;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_written <= '0;
            r_head    <= '0;
            r_fill    <= CNT_W'(2);
        end else begin
            if (i_cmd.push) begin
                r_written[w_slot] <= 1'b1;
                if (w_full) begin
                    r_head <= w_head_inc;
                end else begin
                    r_fill <= r_fill + 1'b1;
                end
            end else if (i_cmd.pop) begin
                r_head <= w_head_inc;
                r_fill <= r_fill - 1'b1;
            end
        end
    end

    // entries never written hold their reset contents: created, then stopped
    assign o_rd_code = r_rd_written ? r_rd_data
                     : ((r_rd_idx == IDX_W'(1)) ? LOG_STOPPED : LOG_CREATED);
    assign o_fill    = r_fill;

endmodule

// ===== rtl/core/lel_ctrl.sv =====
// ----------------------------------------------------------------------------
// lel_ctrl
// Command sequencer: lifecycle flags, lease count, drain loop, result register.
// ----------------------------------------------------------------------------
module lel_ctrl import lel_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    lel_cmd_if.sink          i_cmd,
    lel_res_if.source        o_res,
    output t_ring_cmd        o_ring_cmd,
    input  logic [CNT_W-1:0] i_fill,
    input  t_event           i_rd_code
);

    typedef enum logic [1:0] {S_IDLE, S_RD_ISSUE, S_RD_EMIT} t_state;

    typedef struct packed {
        logic   accepted;
        logic   close_delete;
        logic   is_stopped;
        logic   is_deleting;
        logic   events_pending;
        logic   event_valid;
        t_event event_code;
        logic   last;
    } t_res;

    t_state             r_state, n_state;
    logic               r_stopped, n_stopped;
    logic               r_armed, n_armed;
    logic               r_deleting, n_deleting;
    logic [LEASE_W-1:0] r_lease, n_lease;
    logic [LEFT_W-1:0]  r_left, n_left;
    logic               r_out_valid, n_out_valid;
    t_res               r_res, n_res;

    logic               w_out_free;
    logic               w_accept;
    logic [CAPN_W-1:0]  w_cap_n;
    logic [CAPN_W-1:0]  w_fill_ext;
    logic [CAPN_W-1:0]  w_lim;
    logic [CAPN_W-1:0]  w_take_ext;
    logic [LEFT_W-1:0]  w_take;
    logic [LEASE_W-1:0] w_lease_dec;
    logic               w_go_read;
    logic               w_acc;
    logic               w_cdel;

    assign w_out_free    = !r_out_valid || o_res.ready;
    assign i_cmd.ready   = (r_state == S_IDLE) && w_out_free;
    assign w_accept      = i_cmd.valid && i_cmd.ready;
    assign w_cap_n       = i_cmd.read_capacity[CAP_W-1:BYTE_SHIFT];
    assign w_fill_ext    = CAPN_W'(i_fill);
    assign w_lim         = (w_fill_ext < CAPN_W'(MAX_RESULTS)) ? w_fill_ext
                                                                : CAPN_W'(MAX_RESULTS);
    assign w_take_ext    = (w_cap_n < w_lim) ? w_cap_n : w_lim;
    assign w_take        = w_take_ext[LEFT_W-1:0];
    assign w_lease_dec   = (r_lease != '0) ? r_lease - 1'b1 : r_lease;

    always_comb begin
        n_state     = r_state;
        n_stopped   = r_stopped;
        n_armed     = r_armed;
        n_deleting  = r_deleting;
        n_lease     = r_lease;
        n_left      = r_left;
        n_out_valid = r_out_valid && !o_res.ready;
        n_res       = r_res;
        o_ring_cmd  = '0;
        w_go_read   = 1'b0;
        w_acc       = 1'b1;
        w_cdel      = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    unique case (t_kind'(i_cmd.kind))
                        K_START: begin
                            if (r_stopped) begin
                                n_stopped       = 1'b0;
                                o_ring_cmd.push = 1'b1;
                                o_ring_cmd.code = LOG_STARTED;
                            end
                        end
                        K_STOP: begin
                            if (!r_stopped) begin
                                n_stopped       = 1'b1;
                                o_ring_cmd.push = 1'b1;
                                o_ring_cmd.code = LOG_STOPPED;
                            end
                        end
                        K_LEASE_OPEN: begin
                            if (r_deleting) begin
                                w_acc = 1'b0;
                            end else begin
                                if (r_lease != LEASE_MAX) begin
                                    n_lease = r_lease + 1'b1;
                                end
                                n_armed = 1'b1;
                            end
                        end
                        K_LEASE_CLOSE: begin
                            n_lease = w_lease_dec;
                            if (r_armed && (w_lease_dec == '0) && !r_deleting) begin
                                n_deleting      = 1'b1;
                                o_ring_cmd.push = 1'b1;
                                o_ring_cmd.code = LOG_DELETED;
                                w_cdel          = 1'b1;
                            end
                        end
                        K_BEGIN_DELETE: begin
                            if (r_deleting) begin
                                w_acc = 1'b0;
                            end else begin
                                n_deleting      = 1'b1;
                                o_ring_cmd.push = 1'b1;
                                o_ring_cmd.code = LOG_DELETED;
                            end
                        end
                        K_READ: begin
                            if (w_take != '0) begin
                                w_go_read = 1'b1;
                                n_left    = w_take;
                                n_state   = S_RD_ISSUE;
                            end
                        end
                        default: begin
                            w_acc = 1'b0;
                        end
                    endcase
                    if (!w_go_read) begin
                        n_out_valid          = 1'b1;
                        n_res.accepted       = w_acc;
                        n_res.close_delete   = w_cdel;
                        n_res.is_stopped     = n_stopped;
                        n_res.is_deleting    = n_deleting;
                        n_res.events_pending = o_ring_cmd.push || (i_fill != '0);
                        n_res.event_valid    = 1'b0;
                        n_res.event_code     = LOG_CREATED;
                        n_res.last           = 1'b1;
                    end
                end
            end
            S_RD_ISSUE: begin
                o_ring_cmd.rd_en = 1'b1;
                n_state          = S_RD_EMIT;
            end
            S_RD_EMIT: begin
                if (w_out_free) begin
                    o_ring_cmd.pop       = 1'b1;
                    n_out_valid          = 1'b1;
                    n_res.accepted       = 1'b1;
                    n_res.close_delete   = 1'b0;
                    n_res.is_stopped     = r_stopped;
                    n_res.is_deleting    = r_deleting;
                    n_res.events_pending = (i_fill != CNT_W'(1));
                    n_res.event_valid    = 1'b1;
                    n_res.event_code     = i_rd_code;
                    n_res.last           = (r_left == LEFT_W'(1));
                    n_left               = r_left - 1'b1;
                    n_state              = (r_left == LEFT_W'(1)) ? S_IDLE : S_RD_ISSUE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_stopped   <= 1'b1;
            r_armed     <= 1'b0;
            r_deleting  <= 1'b0;
            r_lease     <= '0;
            r_left      <= '0;
            r_out_valid <= 1'b0;
            r_res       <= '0;
        end else begin
            r_state     <= n_state;
            r_stopped   <= n_stopped;
            r_armed     <= n_armed;
            r_deleting  <= n_deleting;
            r_lease     <= n_lease;
            r_left      <= n_left;
            r_out_valid <= n_out_valid;
            r_res       <= n_res;
        end
    end

    assign o_res.valid          = r_out_valid;
    assign o_res.accepted       = r_res.accepted;
    assign o_res.close_delete   = r_res.close_delete;
    assign o_res.is_stopped     = r_res.is_stopped;
    assign o_res.is_deleting    = r_res.is_deleting;
    assign o_res.events_pending = r_res.events_pending;
    assign o_res.event_valid    = r_res.event_valid;
    assign o_res.event_code     = r_res.event_code;
    assign o_res.last           = r_res.last;

`ifndef SYNTHESIS
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ring_cmd.pop |-> (i_fill != '0))
        else $error("ring pop while empty");

    a_push_pop_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ring_cmd.push |-> !o_ring_cmd.pop)
        else $error("ring push and pop together");

    a_emit_has_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RD_EMIT) |-> (r_left != '0))
        else $error("drain emit with no events left");

    a_issue_then_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RD_ISSUE) |=> (r_state == S_RD_EMIT))
        else $error("ring read not followed by emit");
`endif

endmodule
